### rtl/core/uotd_pkg.sv
// package for the udp-over-tcp to socks5 udp deframer
// holds parse phases, queue command format and framing constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package uotd_pkg;

  // parse phases of the incoming frame
  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_DOMLEN  = 3'd1,
    PH_ADDR    = 3'd2,
    PH_PORT    = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_LEN_LO  = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  // command kinds handed from parser to output sequencer
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,  // one word: data, eop as given
    CMD_HDR  = 2'd1,  // three zero words then the socks address type
    CMD_PORT = 2'd2,  // port high then port low, eop on the second
    CMD_ERR  = 2'd3   // one error word
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] port;
    logic        eop;
  } cmd_t;

  // command queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // incoming address type codes
  localparam logic [7:0] ATYP_IN_IPV4   = 8'h00;
  localparam logic [7:0] ATYP_IN_IPV6   = 8'h01;
  localparam logic [7:0] ATYP_IN_DOMAIN = 8'h02;

  // socks5 address type codes
  localparam logic [7:0] ATYP_SOCKS_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_SOCKS_IPV6   = 8'h04;
  localparam logic [7:0] ATYP_SOCKS_DOMAIN = 8'h03;

  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // field lengths in bytes
  localparam logic [15:0] LEN_IPV4 = 16'd4;
  localparam logic [15:0] LEN_IPV6 = 16'd16;
  localparam logic [15:0] LEN_PORT = 16'd2;

  // index of the final word a command expands into
  function automatic logic [1:0] cmd_last_beat(cmd_kind_e kind);
    logic [1:0] last;
    unique case (kind)
      CMD_HDR:  last = 2'd3;
      CMD_PORT: last = 2'd1;
      default:  last = 2'd0;
    endcase
    return last;
  endfunction

endpackage

`default_nettype wire

### rtl/core/uotd_byte_if.sv
// valid/ready channel carrying one byte of the udp-over-tcp stream
// standalone interface, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface uotd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/uotd_dgram_if.sv
// valid/ready channel carrying one byte of the socks5 udp datagram
// standalone interface, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface uotd_dgram_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic       error;

  modport source(output valid, output out_byte, output end_of_packet, output error,
                 input ready);
  modport sink(input valid, input out_byte, input end_of_packet, input error,
               output ready);
endinterface

`default_nettype wire

### rtl/core/uotd_front.sv
// frame parser: accepts stream words, tracks the frame phase, issues commands
// depends on uotd_pkg and uotd_byte_if
`timescale 1ns / 1ps
`default_nettype none

module uotd_front
  import uotd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  uotd_byte_if.sink   in_i,
  input  wire logic   q_full_i,
  output cmd_t        cmd_o,
  output logic        cmd_push_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic [15:0] port_q, port_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] left_dec;
  logic [15:0] len;

  // take a word whenever the command queue has room
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign b          = in_i.in_byte;
  assign left_dec   = left_q - 16'd1;
  assign len        = {len_hi_q, b};

  // next parse state
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    port_d   = port_q;
    len_hi_d = len_hi_q;
    halted_d = halted_q;
    if (accept && !halted_q) begin
      unique case (phase_q)
        PH_DOMLEN: begin
          if (b == BYTE_ZERO) begin
            phase_d = PH_PORT;
            left_d  = LEN_PORT;
          end else begin
            phase_d = PH_ADDR;
            left_d  = {8'd0, b};
          end
        end
        PH_ADDR: begin
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_PORT;
            left_d  = LEN_PORT;
          end
        end
        PH_PORT: begin
          port_d = {port_q[7:0], b};
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len == 16'd0) begin
            phase_d = PH_TYPE;
            left_d  = 16'd0;
          end else begin
            phase_d = PH_PAYLOAD;
            left_d  = len;
          end
        end
        PH_PAYLOAD: begin
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          port_d   = 16'd0;
          len_hi_d = 8'd0;
          priority case (b)
            ATYP_IN_IPV4: begin
              phase_d = PH_ADDR;
              left_d  = LEN_IPV4;
            end
            ATYP_IN_IPV6: begin
              phase_d = PH_ADDR;
              left_d  = LEN_IPV6;
            end
            ATYP_IN_DOMAIN: begin
              phase_d = PH_DOMLEN;
              left_d  = 16'd0;
            end
            default: begin
              port_d   = port_q;
              len_hi_d = len_hi_q;
              phase_d  = PH_TYPE;
              halted_d = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  // command issued for the accepted word
  always_comb begin
    cmd_push_o = 1'b0;
    cmd_o.kind = CMD_BYTE;
    cmd_o.data = b;
    cmd_o.port = port_q;
    cmd_o.eop  = 1'b0;
    if (accept && !halted_q) begin
      unique case (phase_q)
        PH_DOMLEN, PH_ADDR: begin
          cmd_push_o = 1'b1;
        end
        PH_PORT, PH_LEN_HI: begin
          cmd_push_o = 1'b0;
        end
        PH_LEN_LO: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_PORT;
          cmd_o.eop  = (len == 16'd0);
        end
        PH_PAYLOAD: begin
          cmd_push_o = 1'b1;
          cmd_o.eop  = (left_dec == 16'd0);
        end
        default: begin
          cmd_push_o = 1'b1;
          priority case (b)
            ATYP_IN_IPV4: begin
              cmd_o.kind = CMD_HDR;
              cmd_o.data = ATYP_SOCKS_IPV4;
            end
            ATYP_IN_IPV6: begin
              cmd_o.kind = CMD_HDR;
              cmd_o.data = ATYP_SOCKS_IPV6;
            end
            ATYP_IN_DOMAIN: begin
              cmd_o.kind = CMD_HDR;
              cmd_o.data = ATYP_SOCKS_DOMAIN;
            end
            default: begin
              cmd_o.kind = CMD_ERR;
              cmd_o.data = BYTE_ZERO;
            end
          endcase
        end
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      left_q   <= 16'd0;
      port_q   <= 16'd0;
      len_hi_q <= 8'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      port_q   <= port_d;
      len_hi_q <= len_hi_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/uotd_queue.sv
// small command fifo between the parser and the output sequencer
// depends on uotd_pkg
`timescale 1ns / 1ps
`default_nettype none

module uotd_queue
  import uotd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      head_o
);

  cmd_t             entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/uotd_back.sv
// output sequencer: expands queued commands into datagram words
// depends on uotd_pkg and uotd_dgram_if
`timescale 1ns / 1ps
`default_nettype none

module uotd_back
  import uotd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire cmd_t    head_i,
  output logic         pop_o,
  uotd_dgram_if.source out_o
);

  logic [1:0] beat_q, beat_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       eop_q, eop_d;
  logic       err_q, err_d;

  logic       load;
  logic       take;
  logic [1:0] last;

  // output register frees when empty or being taken
  assign load  = !out_valid_q || out_o.ready;
  assign take  = load && q_valid_i;
  assign last  = cmd_last_beat(head_i.kind);
  assign pop_o = take && (beat_q == last);

  // word for the current beat of the head command
  always_comb begin
    out_byte_d = BYTE_ZERO;
    eop_d      = 1'b0;
    err_d      = 1'b0;
    unique case (head_i.kind)
      CMD_BYTE: begin
        out_byte_d = head_i.data;
        eop_d      = head_i.eop;
      end
      CMD_HDR: begin
        out_byte_d = (beat_q == last) ? head_i.data : BYTE_ZERO;
      end
      CMD_PORT: begin
        out_byte_d = (beat_q == 2'd0) ? head_i.port[15:8] : head_i.port[7:0];
        eop_d      = (beat_q == last) && head_i.eop;
      end
      CMD_ERR: begin
        err_d = 1'b1;
      end
    endcase
  end

  // beat counter and output valid
  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = q_valid_i;
    end
    if (take) begin
      beat_d = (beat_q == last) ? 2'd0 : beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= out_byte_d;
      eop_q      <= eop_d;
      err_q      <= err_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.end_of_packet = eop_q;
  assign out_o.error         = err_q;

endmodule

`default_nettype wire

### rtl/core/uot_to_socks_udp_deframer_top.sv
// top level of the udp-over-tcp to socks5 udp deframer
// depends on uotd_pkg, uotd_byte_if, uotd_dgram_if, uotd_front, uotd_queue, uotd_back
//
//   channel | dir | payload                          | handshake
//   in_i    | in  | in_byte[7:0]                     | valid/ready
//   out_o   | out | out_byte[7:0], end_of_packet, error | valid/ready
//
// one stream word is taken per cycle while the 4-entry command queue has room
// a frame header word expands to four output words and the port to two, so the
// output side sets the rate in bursts: the sequencer emits one word per cycle while out_o is ready
// output words are registered in the sequencer once their command reaches the queue head
// asynchronous active-low reset clears parser, queue and output valid
// after an invalid address type one error word is sent and input words are
// then consumed without effect until reset
`timescale 1ns / 1ps
`default_nettype none

module uot_to_socks_udp_deframer_top
  import uotd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  uotd_byte_if.sink    in_i,
  uotd_dgram_if.source out_o
);

  cmd_t cmd;
  logic cmd_push;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  // parser
  uotd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .cmd_o      (cmd),
    .cmd_push_o (cmd_push)
  );

  // decoupling queue
  uotd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // output sequencer
  uotd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  // an error word carries a zero byte and no end mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.out_byte == BYTE_ZERO && !out_o.end_of_packet)
    else $error("error word with nonzero byte or end mark");

  // the sequencer never retires a command from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // the parser never issues a command into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !q_full)
    else $error("push into full command queue");
`endif

endmodule

`default_nettype wire

### tb/sv/uot_to_socks_udp_deframer_top_tb.sv
// testbench for the udp-over-tcp to socks5 udp deframer top level
// depends on uotd_pkg, uotd_byte_if, uotd_dgram_if and uot_to_socks_udp_deframer_top
// drives framed streams with random gaps and stalls, checks every datagram word in order
`timescale 1ns / 1ps

module uot_to_socks_udp_deframer_top_tb;
  import uotd_pkg::*;

  // longest run of cycles with no word moving on either side before giving up
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_WAIT = 18;
  localparam int unsigned RANDOM_WORDS = 60;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       err;
  } dgram_word_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZEROS,
    FILL_ONES
  } fill_e;

  logic clk_i;
  logic rst_ni;

  uotd_byte_if  in_if ();
  uotd_dgram_if out_if ();

  uot_to_socks_udp_deframer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // expected datagram words, oldest first
  dgram_word_t dgram_expected[$];

  // tracked parser state
  phase_e      trk_phase;
  logic [15:0] trk_left;
  logic [15:0] trk_port;
  logic [7:0]  trk_len_hi;
  logic        trk_halted;

  int unsigned mismatches;
  int unsigned words_taken;
  int unsigned idle_cycles;
  bit          in_rush;
  bit          out_rush;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait(input bit rush);
    return rush ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] fill_byte(input fill_e fill);
    case (fill)
      FILL_ZEROS: return 8'h00;
      FILL_ONES:  return 8'hff;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(input logic [7:0] data, input logic eop, input logic err);
    dgram_word_t w;
    w.data = data;
    w.eop  = eop;
    w.err  = err;
    dgram_expected = {dgram_expected, w};
  endtask

  // advance the tracked parser by one stream word and queue the datagram words it yields
  task automatic deframe_predict(input logic [7:0] b);
    logic [15:0] len;
    logic [7:0]  socks_type;
    if (trk_halted) return;
    case (trk_phase)
      PH_DOMLEN: begin
        push_word(b, 1'b0, 1'b0);
        if (b == 8'h00) begin
          trk_phase = PH_PORT;
          trk_left  = LEN_PORT;
        end else begin
          trk_phase = PH_ADDR;
          trk_left  = {8'h00, b};
        end
      end
      PH_ADDR: begin
        push_word(b, 1'b0, 1'b0);
        trk_left = trk_left - 16'd1;
        if (trk_left == 16'd0) begin
          trk_phase = PH_PORT;
          trk_left  = LEN_PORT;
        end
      end
      PH_PORT: begin
        // port is held back until the length is known
        trk_port = {trk_port[7:0], b};
        trk_left = trk_left - 16'd1;
        if (trk_left == 16'd0) trk_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        trk_len_hi = b;
        trk_phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {trk_len_hi, b};
        push_word(trk_port[15:8], 1'b0, 1'b0);
        push_word(trk_port[7:0], len == 16'd0, 1'b0);
        if (len == 16'd0) begin
          trk_phase = PH_TYPE;
          trk_left  = 16'd0;
        end else begin
          trk_phase = PH_PAYLOAD;
          trk_left  = len;
        end
      end
      PH_PAYLOAD: begin
        trk_left = trk_left - 16'd1;
        push_word(b, trk_left == 16'd0, 1'b0);
        if (trk_left == 16'd0) trk_phase = PH_TYPE;
      end
      default: begin
        if (b == ATYP_IN_IPV4) begin
          socks_type = ATYP_SOCKS_IPV4;
          trk_left   = LEN_IPV4;
          trk_phase  = PH_ADDR;
        end else if (b == ATYP_IN_IPV6) begin
          socks_type = ATYP_SOCKS_IPV6;
          trk_left   = LEN_IPV6;
          trk_phase  = PH_ADDR;
        end else if (b == ATYP_IN_DOMAIN) begin
          socks_type = ATYP_SOCKS_DOMAIN;
          trk_left   = 16'd0;
          trk_phase  = PH_DOMLEN;
        end else begin
          // unknown type: one error word, then nothing until reset
          trk_halted = 1'b1;
          trk_phase  = PH_TYPE;
          push_word(BYTE_ZERO, 1'b0, 1'b1);
          return;
        end
        trk_port   = 16'd0;
        trk_len_hi = 8'h00;
        repeat (3) push_word(BYTE_ZERO, 1'b0, 1'b0);
        push_word(socks_type, 1'b0, 1'b0);
      end
    endcase
  endtask

  // send one stream word after a random gap and track it once taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) in_rush = !in_rush;
    gap = draw_wait(in_rush);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!trk_halted) words_taken++;
    deframe_predict(b);
  endtask

  task automatic send_frame(input logic [7:0] atyp, input int dom_len, input int pay_len,
                            input fill_e fill);
    int n_addr;
    send_byte(atyp);
    if (atyp == ATYP_IN_DOMAIN) begin
      send_byte(dom_len[7:0]);
      n_addr = dom_len;
    end else begin
      n_addr = (atyp == ATYP_IN_IPV4) ? int'(LEN_IPV4) : int'(LEN_IPV6);
    end
    repeat (n_addr) send_byte(fill_byte(fill));
    repeat (2) send_byte(fill_byte(fill));
    send_byte(pay_len[15:8]);
    send_byte(pay_len[7:0]);
    repeat (pay_len) send_byte(fill_byte(fill));
  endtask

  // empty domain followed directly by the port, and an empty payload
  task automatic test_empty_domain_and_payload();
    send_frame(ATYP_IN_DOMAIN, 0, 0, FILL_ZEROS);
  endtask

  // ipv4 frame with every content byte at its top value
  task automatic test_ipv4_all_ones();
    send_frame(ATYP_IN_IPV4, 0, 1, FILL_ONES);
  endtask

  // long domain and a payload length with a nonzero high byte
  task automatic test_long_fields();
    send_frame(ATYP_IN_DOMAIN, 48, 2, FILL_RANDOM);
    send_frame(ATYP_IN_IPV4, 0, 16'h0100 + int'($urandom_range(0, 3)), FILL_RANDOM);
  endtask

  // well-formed frames of every type with random content and small sizes
  task automatic test_random_frames();
    int unsigned start;
    int unsigned kind;
    int          dom_len;
    int          pay_len;
    logic [7:0]  atyp;
    start = words_taken;
    while (words_taken - start < RANDOM_WORDS) begin
      kind = $urandom_range(0, 2);
      atyp = (kind == 0) ? ATYP_IN_IPV4 : (kind == 1) ? ATYP_IN_IPV6 : ATYP_IN_DOMAIN;
      dom_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      pay_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
      send_frame(atyp, dom_len, pay_len, FILL_RANDOM);
    end
  endtask

  // unknown address type halts the block; later words must yield nothing
  task automatic test_bad_type();
    send_byte(8'($urandom_range(3, 255)));
    send_byte(ATYP_IN_IPV4);
    repeat (8) send_byte(8'($urandom_range(0, 255)));
  endtask

  // output ready with random stalls per word
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) out_rush = !out_rush;
      stall = draw_wait(out_rush);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // compare each datagram word with the oldest expectation
  always @(posedge clk_i) begin
    dgram_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (dgram_expected.size() == 0) begin
        $display("%0t: unexpected word expected none actual %02h eop %0b err %0b", $time,
                 out_if.out_byte, out_if.end_of_packet, out_if.error);
        mismatches++;
      end else begin
        want = dgram_expected.pop_front();
        if (out_if.out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                   out_if.out_byte);
          mismatches++;
        end
        if (out_if.end_of_packet !== want.eop) begin
          $display("%0t: end_of_packet expected %0b actual %0b", $time, want.eop,
                   out_if.end_of_packet);
          mismatches++;
        end
        if (out_if.error !== want.err) begin
          $display("%0t: error expected %0b actual %0b", $time, want.err, out_if.error);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // reset, run the tests in turn, drain and report
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    mismatches  = 0;
    words_taken = 0;
    idle_cycles = 0;
    in_rush     = 1'b0;
    out_rush    = 1'b0;
    trk_phase   = PH_TYPE;
    trk_left    = 16'd0;
    trk_port    = 16'd0;
    trk_len_hi  = 8'h00;
    trk_halted  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_domain_and_payload();
    test_ipv4_all_ones();
    test_long_fields();
    test_random_frames();
    test_bad_type();

    in_if.valid <= 1'b0;
    while (dgram_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && dgram_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
